[rtl/irt_pkg.sv]
// Package for the interval reservation table.
// Holds the default sizes, status codes and the controller/datapath link types.
// No dependencies.
package irt_pkg;

    localparam int IRT_ENTRIES   = 64;
    localparam int IRT_TIME_BITS = 32;
    localparam int IN_W          = 32;
    localparam int STATUS_W      = 2;

    localparam logic [STATUS_W-1:0] STATUS_BOOKED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERLAP = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic start;   // latch request, restart the scan
        logic scan;    // issue reads / check entries
        logic commit;  // decide, store if booked, load status
    } irt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;        // entry under check overlaps the request
        logic scan_done;  // all stored entries checked
    } irt_sts_t;

endpackage

[rtl/interval_reservation_table.sv]
// Interval reservation table, top level: controller plus datapath.
// Depends on irt_pkg, irt_ctrl, irt_dp (and irt_ram below it).
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  in      | in_valid / in_stall  | interval_start, interval_end
//  out     | out_valid / out_stall| status
//
// From accept, the stored entries are scanned in order, ended early by an overlap;
// one entry is read and checked a cycle through the store's registered port, then
// a commit step. Input free again after the commit.
// Reset empties the table at once; no clearing pass. A stalled result is held in
// the output register; the next item may be accepted meanwhile, but its commit
// waits until the register is free.
module interval_reservation_table #(
    parameter int ENTRIES   = irt_pkg::IRT_ENTRIES,
    parameter int TIME_BITS = irt_pkg::IRT_TIME_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [irt_pkg::IN_W-1:0]     interval_start,
    input  logic [irt_pkg::IN_W-1:0]     interval_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [irt_pkg::STATUS_W-1:0] status
);

    irt_pkg::irt_cmd_t cmd;
    irt_pkg::irt_sts_t sts;

    irt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    irt_dp #(
        .ENTRIES   (ENTRIES),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .interval_start (interval_start),
        .interval_end   (interval_end),
        .status         (status),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

[rtl/irt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module irt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/irt_ctrl.sv]
// Controller for the interval reservation table: sequences accept, scan and commit,
// and owns the result valid flag. Depends on irt_pkg.
module irt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output irt_pkg::irt_cmd_t cmd,
    input  irt_pkg::irt_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   commit;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);
    // result register must be free, or emptied this cycle
    assign commit   = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.hit || sts.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cmd.start  = accept;
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.commit = commit;

endmodule

[rtl/irt_dp.sv]
// Datapath for the interval reservation table: request registers, entry store,
// scan counter, shared overlap comparator and status register.
// Depends on irt_pkg and irt_ram.
module irt_dp #(
    parameter int ENTRIES   = irt_pkg::IRT_ENTRIES,
    parameter int TIME_BITS = irt_pkg::IRT_TIME_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [irt_pkg::IN_W-1:0]      interval_start,
    input  logic [irt_pkg::IN_W-1:0]      interval_end,
    output logic [irt_pkg::STATUS_W-1:0]  status,
    input  irt_pkg::irt_cmd_t             cmd,
    output irt_pkg::irt_sts_t             sts
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);
    localparam int IN_W_EXT = irt_pkg::IN_W + TIME_BITS;

    logic [IN_W_EXT-1:0] start_ext, end_ext;

    logic [TIME_BITS-1:0]          lo_reg, hi_reg;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic                          chk_reg, chk_next;
    logic                          hit_reg, hit_next;
    logic [irt_pkg::STATUS_W-1:0]  status_reg;

    logic                          rd_en;
    logic                          wr_en;
    logic [2*TIME_BITS-1:0]        rd_data;
    logic [TIME_BITS-1:0]          ent_s, ent_e;
    logic                          hit_now;
    logic                          full;
    logic [irt_pkg::STATUS_W-1:0]  status_next;

    // zero-extend, then keep the low TIME_BITS
    assign start_ext = {{TIME_BITS{1'b0}}, interval_start};
    assign end_ext   = {{TIME_BITS{1'b0}}, interval_end};

    assign rd_en   = cmd.scan && (idx_reg != count_reg);
    assign ent_s   = rd_data[2*TIME_BITS-1:TIME_BITS];
    assign ent_e   = rd_data[TIME_BITS-1:0];
    assign hit_now = chk_reg && !((hi_reg <= ent_s) || (lo_reg >= ent_e));
    assign full    = (count_reg == CNT_FULL);

    assign sts.hit       = hit_now;
    assign sts.scan_done = (idx_reg == count_reg) && !chk_reg;

    always_comb
    begin
        if (hit_reg)
        begin
            status_next = irt_pkg::STATUS_OVERLAP;
        end
        else if (full)
        begin
            status_next = irt_pkg::STATUS_FULL;
        end
        else
        begin
            status_next = irt_pkg::STATUS_BOOKED;
        end
    end

    assign wr_en = cmd.commit && !hit_reg && !full;

    always_comb
    begin
        idx_next   = idx_reg;
        chk_next   = 1'b0;
        hit_next   = hit_reg;
        count_next = count_reg;
        if (cmd.start)
        begin
            idx_next = '0;
            hit_next = 1'b0;
        end
        else if (cmd.scan)
        begin
            chk_next = rd_en;
            if (rd_en)
            begin
                idx_next = idx_reg + 1'b1;
            end
            if (hit_now)
            begin
                hit_next = 1'b1;
            end
        end
        if (wr_en)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            chk_reg   <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            chk_reg   <= chk_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            lo_reg <= start_ext[TIME_BITS-1:0];
            hi_reg <= end_ext[TIME_BITS-1:0];
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
        end
    end

    irt_ram #(
        .WIDTH (2 * TIME_BITS),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data ({lo_reg, hi_reg}),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign status = status_reg;

endmodule
